[rtl/salc_pkg.sv]
// Shared types and constants of the set-associative LRU cache classifier.
package salc_pkg;

  localparam logic [1:0] OUT_HIT        = 2'd0;
  localparam logic [1:0] OUT_COMPULSORY = 2'd1;
  localparam logic [1:0] OUT_CONFLICT   = 2'd2;

  localparam logic REG_NUM_SETS = 1'b0;
  localparam logic REG_WAYS     = 1'b1;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 9;
  localparam int SETS_BITS     = 9;
  localparam int WAYS_BITS     = 4;
  localparam int OUTCOME_BITS  = 2;
  localparam int WAY_OUT_BITS  = 3;

endpackage

[rtl/salc_in_if.sv]
// Request channel interface carrying one block address.
interface salc_in_if #(parameter int ADDR_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

[rtl/salc_out_if.sv]
// Result channel interface carrying the outcome and the way used.
interface salc_out_if;
  logic                                valid;
  logic                                ready;
  logic [salc_pkg::OUTCOME_BITS-1:0]   outcome;
  logic [salc_pkg::WAY_OUT_BITS-1:0]   way_used;
  modport source (output valid, output outcome, output way_used, input ready);
  modport sink (input valid, input outcome, input way_used, output ready);
endinterface

[rtl/salc_cfg_if.sv]
// Configuration write channel interface.
interface salc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [salc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [salc_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/set_assoc_lru_cache_classifier.sv]
// Top level of the set-associative LRU cache classifier.
//
//   channel   direction  handshake             payload
//   in_req    sink       valid/ready           address
//   out_res   source     valid/ready           outcome, way_used
//   cfg       sink       valid/ready           index, data
//
// Each request runs a bit-serial divider for set and tag, then a set read, a
// seen-map read and a write back; a new request is taken only once its result
// has moved into the output register.
// After reset a clearing pass runs on the valid and seen memories; no request is
// taken during it.
// A stalled result is held in the output register while the next request runs;
// that request waits in its last step until the output register is free.
module set_assoc_lru_cache_classifier #(
  parameter int MAX_SETS  = 256,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  salc_in_if.sink    in_req,
  salc_out_if.source out_res,
  salc_cfg_if.sink   cfg
);

  localparam int SET_BITS  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_BITS = WAY_BITS;
  localparam int CNT_BITS  = $clog2(ADDR_BITS + 1);
  localparam int SEEN_W    = 32;
  localparam int SEEN_ROWS = ((1 << ADDR_BITS) + SEEN_W - 1) / SEEN_W;
  localparam int SROW_BITS = (SEEN_ROWS > 1) ? $clog2(SEEN_ROWS) : 1;
  localparam int SBIT_BITS = $clog2(SEEN_W);
  localparam int CLR_BITS  = ((SEEN_ROWS > MAX_SETS) ? $clog2(SEEN_ROWS + 1)
                                                     : $clog2(MAX_SETS + 1));
  localparam int DIV_W     = salc_pkg::SETS_BITS + 1;
  localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(MAX_WAYS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  typedef logic [ADDR_BITS-1:0]          tag_t;
  typedef logic [RANK_BITS-1:0]          rank_t;
  typedef logic [MAX_WAYS-1:0]           vmask_t;
  typedef tag_t  [MAX_WAYS-1:0]          tag_row_t;
  typedef rank_t [MAX_WAYS-1:0]          rank_row_t;

  vmask_t    valid_mem [MAX_SETS];
  tag_row_t  tag_mem   [MAX_SETS];
  rank_row_t rank_mem  [MAX_SETS];
  logic [SEEN_W-1:0] seen_mem [SEEN_ROWS];

  logic [2:0]                     state_r;
  logic [CLR_BITS-1:0]            clr_r;
  logic [salc_pkg::SETS_BITS-1:0] num_sets_r;
  logic [salc_pkg::WAYS_BITS-1:0] ways_r;
  logic [ADDR_BITS-1:0]           addr_r, quo_r;
  logic [DIV_W-1:0]               rem_r;
  logic [CNT_BITS-1:0]            cnt_r;
  logic [SET_BITS-1:0]            set_r;
  vmask_t                         vrow_r;
  tag_row_t                       trow_r;
  rank_row_t                      rrow_r;
  logic [SEEN_W-1:0]              srow_r;
  logic                           out_valid_r;
  logic [salc_pkg::OUTCOME_BITS-1:0] outcome_r;
  logic [salc_pkg::WAY_OUT_BITS-1:0] way_used_r;
  logic [salc_pkg::OUTCOME_BITS-1:0] res_outcome_r;
  logic [salc_pkg::WAY_OUT_BITS-1:0] res_way_r;

  logic [salc_pkg::SETS_BITS-1:0] ns_use;
  logic [WAY_BITS:0]              nw_use;
  logic [DIV_W-1:0]               rem_sh;
  logic                           rem_ge;

  always_comb begin
    if (num_sets_r == '0) ns_use = salc_pkg::SETS_BITS'(1);
    else if (32'(num_sets_r) > MAX_SETS) ns_use = salc_pkg::SETS_BITS'(MAX_SETS);
    else ns_use = num_sets_r;
    if (ways_r == '0) nw_use = (WAY_BITS+1)'(1);
    else if (32'(ways_r) > MAX_WAYS) nw_use = (WAY_BITS+1)'(MAX_WAYS);
    else nw_use = (WAY_BITS+1)'(ways_r);
    rem_sh = {rem_r[DIV_W-2:0], addr_r[ADDR_BITS-1]};
    rem_ge = rem_sh >= {1'b0, ns_use};
  end

  // Hit, victim and recency update.
  vmask_t    in_use;
  logic      hit;
  logic [WAY_BITS-1:0] hit_way, inv_way, lru_way, vic_way;
  logic      any_inv;
  rank_t     best, limit;
  logic      lim_all;
  vmask_t    vrow_nxt;
  tag_row_t  trow_nxt;
  rank_row_t rrow_nxt;
  logic [SROW_BITS-1:0] srow_idx;
  logic [SBIT_BITS-1:0] sbit_idx;

  always_comb begin
    hit = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    lru_way = '0; best = rrow_r[0];
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (i < 32'(nw_use));
      if (!hit && in_use[i] && vrow_r[i] && trow_r[i] == quo_r) begin
        hit = 1'b1; hit_way = WAY_BITS'(i);
      end
      if (!any_inv && in_use[i] && !vrow_r[i]) begin
        any_inv = 1'b1; inv_way = WAY_BITS'(i);
      end
      if (i > 0 && in_use[i] && rrow_r[i] > best) begin
        best = rrow_r[i]; lru_way = WAY_BITS'(i);
      end
    end
    if (hit) begin
      vic_way = hit_way; limit = rrow_r[hit_way]; lim_all = 1'b0;
    end else if (any_inv) begin
      vic_way = inv_way; limit = '0; lim_all = 1'b1;
    end else begin
      vic_way = lru_way; limit = best; lim_all = 1'b0;
    end
    vrow_nxt = vrow_r; trow_nxt = trow_r; rrow_nxt = rrow_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && vrow_r[i] && WAY_BITS'(i) != vic_way
          && (lim_all || rrow_r[i] < limit) && rrow_r[i] != RANK_MAX)
        rrow_nxt[i] = rrow_r[i] + rank_t'(1);
    end
    rrow_nxt[vic_way] = '0;
    vrow_nxt[vic_way] = 1'b1;
    trow_nxt[vic_way] = quo_r;
    srow_idx = SROW_BITS'(addr_r >> SBIT_BITS);
    sbit_idx = SBIT_BITS'(addr_r);
  end

  assign in_req.ready  = (state_r == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign out_res.valid    = out_valid_r;
  assign out_res.outcome  = outcome_r;
  assign out_res.way_used = way_used_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (32'(clr_r) < MAX_SETS) valid_mem[SET_BITS'(clr_r)] <= '0;
      if (32'(clr_r) < SEEN_ROWS) seen_mem[SROW_BITS'(clr_r)] <= '0;
    end else if (state_r == ST_EVAL) begin
      valid_mem[set_r] <= vrow_nxt;
      tag_mem[set_r]   <= trow_nxt;
      rank_mem[set_r]  <= rrow_nxt;
      if (!hit) seen_mem[srow_idx][sbit_idx] <= 1'b1;
    end
    vrow_r <= valid_mem[set_r];
    trow_r <= tag_mem[set_r];
    rrow_r <= rank_mem[set_r];
    srow_r <= seen_mem[srow_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      num_sets_r  <= salc_pkg::SETS_BITS'(256);
      ways_r      <= salc_pkg::WAYS_BITS'(8);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == salc_pkg::REG_NUM_SETS) num_sets_r <= cfg.data;
        else ways_r <= salc_pkg::WAYS_BITS'(cfg.data);
      end
      if (out_valid_r && out_res.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + CLR_BITS'(1);
          if (32'(clr_r) >= MAX_SETS - 1 && 32'(clr_r) >= SEEN_ROWS - 1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            addr_r  <= in_req.address;
            quo_r   <= in_req.address;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_ge ? rem_sh - {1'b0, ns_use} : rem_sh;
          quo_r <= {quo_r[ADDR_BITS-2:0], rem_ge};
          addr_r <= {addr_r[ADDR_BITS-2:0], addr_r[ADDR_BITS-1]};
          cnt_r <= cnt_r + CNT_BITS'(1);
          if (32'(cnt_r) == ADDR_BITS - 1) begin
            state_r <= ST_READ;
            set_r   <= SET_BITS'(rem_ge ? rem_sh - {1'b0, ns_use} : rem_sh);
          end
        end
        ST_READ: state_r <= ST_EVAL;
        ST_EVAL: begin
          res_outcome_r <= hit ? salc_pkg::OUT_HIT :
                           (srow_r[sbit_idx] ? salc_pkg::OUT_CONFLICT
                                             : salc_pkg::OUT_COMPULSORY);
          res_way_r     <= salc_pkg::WAY_OUT_BITS'(vic_way);
          state_r       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            outcome_r   <= res_outcome_r;
            way_used_r  <= res_way_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
